>>> hdl/cbpe_pkg.sv
// ----------------------------------------------------------------------------
// cbpe_pkg
// Widths, types and helpers shared by the cubic Bezier point evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package cbpe_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int T_FRAC_BITS = 16;
  localparam int T_WIDTH     = T_FRAC_BITS + 1;
  localparam int N_AXES      = 2;
  localparam int N_STAGES    = 5;

  // Polynomial coefficient widths
  localparam int C1_WIDTH   = COORD_WIDTH + 3;
  localparam int C2_WIDTH   = COORD_WIDTH + 4;
  localparam int C3_WIDTH   = COORD_WIDTH + 4;

  // Horner accumulators
  localparam int ACC1_WIDTH = C3_WIDTH + T_WIDTH + 1;
  localparam int ACC2_WIDTH = ACC1_WIDTH + T_WIDTH + 1;
  localparam int SPLIT_LO   = ACC2_WIDTH / 2;
  localparam int SPLIT_HI   = ACC2_WIDTH - SPLIT_LO;
  localparam int PLO_WIDTH  = SPLIT_LO + T_WIDTH;
  localparam int PHI_WIDTH  = SPLIT_HI + T_WIDTH + 1;
  localparam int SUM_WIDTH  = COORD_WIDTH + 3 * T_FRAC_BITS;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic        [T_WIDTH-1:0]     tpar_t;
  typedef logic signed [C1_WIDTH-1:0]    c1_t;
  typedef logic signed [C2_WIDTH-1:0]    c2_t;
  typedef logic signed [C3_WIDTH-1:0]    c3_t;
  typedef logic signed [ACC1_WIDTH-1:0]  acc1_t;
  typedef logic signed [ACC2_WIDTH-1:0]  acc2_t;
  typedef logic        [PLO_WIDTH-1:0]   plo_t;
  typedef logic signed [PHI_WIDTH-1:0]   phi_t;
  typedef logic        [SUM_WIDTH-1:0]   sum_t;

  localparam tpar_t T_ONE = tpar_t'(1) << T_FRAC_BITS;

  // Parameter above 1.0 clamps to 1.0
  function automatic tpar_t sat_t(input tpar_t t);
    return (t > T_ONE) ? T_ONE : t;
  endfunction

endpackage

`default_nettype wire

>>> hdl/cbpe_if.sv
// ----------------------------------------------------------------------------
// cbpe_if
// Valid/ready channels: control points plus parameter in, curve point out.
// ----------------------------------------------------------------------------
`default_nettype none

interface cbpe_in_if;
  import cbpe_pkg::*;

  logic   valid;
  logic   ready;
  coord_t ctrl0_x;
  coord_t ctrl0_y;
  coord_t ctrl1_x;
  coord_t ctrl1_y;
  coord_t ctrl2_x;
  coord_t ctrl2_y;
  coord_t ctrl3_x;
  coord_t ctrl3_y;
  tpar_t  param_t;

  modport source (
    output valid, ctrl0_x, ctrl0_y, ctrl1_x, ctrl1_y,
           ctrl2_x, ctrl2_y, ctrl3_x, ctrl3_y, param_t,
    input  ready
  );
  modport sink (
    input  valid, ctrl0_x, ctrl0_y, ctrl1_x, ctrl1_y,
           ctrl2_x, ctrl2_y, ctrl3_x, ctrl3_y, param_t,
    output ready
  );
endinterface

interface cbpe_out_if;
  import cbpe_pkg::*;

  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;

  modport source (output valid, point_x, point_y, input ready);
  modport sink   (input valid, point_x, point_y, output ready);
endinterface

`default_nettype wire

>>> hdl/cubic_bezier_point_eval.sv
// ----------------------------------------------------------------------------
// cubic_bezier_point_eval
// Evaluates one point of a 2-D cubic Bezier curve per beat by Horner's rule.
// Throughput: one beat per cycle while the output is ready; each stage holds one item and the last
// stage is the output register, so bubbles close up while the output waits.
// Stages: coefficients, c3*t+c2, *t+c1, split partial products, sum/round.
// Reset (rst, synchronous) clears the stage valid bits only.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_bezier_point_eval (
  input  wire logic   clk,
  input  wire logic   rst,
  cbpe_in_if.sink     ctrl_in,
  cbpe_out_if.source  point_out
);
  import cbpe_pkg::*;

  logic [N_STAGES:1] v;
  logic [N_STAGES:1] en;
  logic [N_STAGES:1] v_src;

  // Stage 1: coefficients
  coord_t s1_p0 [N_AXES];
  c1_t    s1_c1 [N_AXES];
  c2_t    s1_c2 [N_AXES];
  c3_t    s1_c3 [N_AXES];
  tpar_t  s1_t;
  // Stage 2
  coord_t s2_p0   [N_AXES];
  c1_t    s2_c1   [N_AXES];
  acc1_t  s2_acc1 [N_AXES];
  tpar_t  s2_t;
  // Stage 3
  coord_t s3_p0   [N_AXES];
  acc2_t  s3_acc2 [N_AXES];
  tpar_t  s3_t;
  // Stage 4
  coord_t s4_p0  [N_AXES];
  plo_t   s4_plo [N_AXES];
  phi_t   s4_phi [N_AXES];
  // Stage 5 (output register)
  coord_t s5_pt  [N_AXES];

  coord_t in_p0 [N_AXES];
  coord_t in_p1 [N_AXES];
  coord_t in_p2 [N_AXES];
  coord_t in_p3 [N_AXES];

  always_comb begin
    in_p0[0] = ctrl_in.ctrl0_x;
    in_p0[1] = ctrl_in.ctrl0_y;
    in_p1[0] = ctrl_in.ctrl1_x;
    in_p1[1] = ctrl_in.ctrl1_y;
    in_p2[0] = ctrl_in.ctrl2_x;
    in_p2[1] = ctrl_in.ctrl2_y;
    in_p3[0] = ctrl_in.ctrl3_x;
    in_p3[1] = ctrl_in.ctrl3_y;
  end

  // Per-stage advance: a stage loads when it is empty or its successor moves
  always_comb begin
    en[N_STAGES] = !v[N_STAGES] || point_out.ready;
    for (int k = N_STAGES - 1; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign v_src         = {v[N_STAGES-1:1], ctrl_in.valid};
  assign ctrl_in.ready = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 1; k <= N_STAGES; k++) begin
        if (en[k]) begin
          v[k] <= v_src[k];
        end
      end
    end
  end

  // Stage 1
  c1_t d1 [N_AXES];
  c2_t d2 [N_AXES];
  c3_t d3 [N_AXES];

  always_comb begin
    for (int a = 0; a < N_AXES; a++) begin
      d1[a] = C1_WIDTH'(in_p1[a]) - C1_WIDTH'(in_p0[a]);
      d2[a] = C2_WIDTH'(in_p0[a]) - (C2_WIDTH'(in_p1[a]) <<< 1) + C2_WIDTH'(in_p2[a]);
      d3[a] = C3_WIDTH'(in_p1[a]) - C3_WIDTH'(in_p2[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int a = 0; a < N_AXES; a++) begin
        s1_p0[a] <= in_p0[a];
        s1_c1[a] <= d1[a] + (d1[a] <<< 1);
        s1_c2[a] <= d2[a] + (d2[a] <<< 1);
        s1_c3[a] <= d3[a] + (d3[a] <<< 1) + C3_WIDTH'(in_p3[a]) - C3_WIDTH'(in_p0[a]);
      end
      s1_t <= sat_t(ctrl_in.param_t);
    end
  end

  // Stage 2: c3*t + c2
  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int a = 0; a < N_AXES; a++) begin
        s2_p0[a]   <= s1_p0[a];
        s2_c1[a]   <= s1_c1[a];
        s2_acc1[a] <= ACC1_WIDTH'(s1_c3[a]) * ACC1_WIDTH'($signed({1'b0, s1_t}))
                    + (ACC1_WIDTH'(s1_c2[a]) <<< T_FRAC_BITS);
      end
      s2_t <= s1_t;
    end
  end

  // Stage 3: acc1*t + c1
  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int a = 0; a < N_AXES; a++) begin
        s3_p0[a]   <= s2_p0[a];
        s3_acc2[a] <= ACC2_WIDTH'(s2_acc1[a]) * ACC2_WIDTH'($signed({1'b0, s2_t}))
                    + (ACC2_WIDTH'(s2_c1[a]) <<< (2 * T_FRAC_BITS));
      end
      s3_t <= s2_t;
    end
  end

  // Stage 4: acc2*t as two narrow partial products
  logic signed [SPLIT_HI-1:0] acc2_hi [N_AXES];
  logic        [SPLIT_LO-1:0] acc2_lo [N_AXES];

  always_comb begin
    for (int a = 0; a < N_AXES; a++) begin
      acc2_hi[a] = s3_acc2[a][ACC2_WIDTH-1:SPLIT_LO];
      acc2_lo[a] = s3_acc2[a][SPLIT_LO-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int a = 0; a < N_AXES; a++) begin
        s4_p0[a]  <= s3_p0[a];
        s4_plo[a] <= PLO_WIDTH'(acc2_lo[a]) * PLO_WIDTH'(s3_t);
        s4_phi[a] <= PHI_WIDTH'(acc2_hi[a]) * PHI_WIDTH'($signed({1'b0, s3_t}));
      end
    end
  end

  // Stage 5: recombine, add p0, round half up
  sum_t sum [N_AXES];

  always_comb begin
    for (int a = 0; a < N_AXES; a++) begin
      sum[a] = (SUM_WIDTH'(s4_phi[a]) << SPLIT_LO) + SUM_WIDTH'(s4_plo[a])
             + (SUM_WIDTH'(s4_p0[a]) << (3 * T_FRAC_BITS))
             + (SUM_WIDTH'(1) << (3 * T_FRAC_BITS - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int a = 0; a < N_AXES; a++) begin
        s5_pt[a] <= sum[a][SUM_WIDTH-1 -: COORD_WIDTH];
      end
    end
  end

  assign point_out.valid   = v[N_STAGES];
  assign point_out.point_x = s5_pt[0];
  assign point_out.point_y = s5_pt[1];

  // Checks
  a_ready_follows_out: assert property (@(posedge clk) disable iff (rst)
    point_out.ready |-> ctrl_in.ready)
    else $error("input stalled while output drains");

  a_full_stalls_in: assert property (@(posedge clk) disable iff (rst)
    (&v) && !point_out.ready |-> !ctrl_in.ready)
    else $error("input accepted into a full pipeline");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !point_out.valid)
    else $error("output valid straight after reset");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    ctrl_in.valid && ctrl_in.ready |=> v[1])
    else $error("accepted beat lost at first stage");

endmodule

`default_nettype wire
